// File: design/msds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msds_pkg
// Types, codes and the per-step micro-program of the second-derivative sum.
// ----------------------------------------------------------------------------
package msds_pkg;

    typedef struct packed {
        logic signed [31:0] point_re;
        logic signed [31:0] point_im;
    } t_point;

    typedef struct packed {
        logic [47:0] magnitude;
        logic        escaped;
        logic        saturated;
    } t_result;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_ITER  = 2'd0;
    localparam logic [1:0] REG_REG_FIRST = 2'd1;
    localparam logic [1:0] REG_REG_STEP  = 2'd2;
    localparam logic [1:0] REG_ESC_LIMIT = 2'd3;

    localparam logic [12:0] RST_MAX_ITER  = 13'd256;
    localparam logic [31:0] RST_REG_FIRST = 32'd4278223000;
    localparam logic [31:0] RST_REG_STEP  = 32'd4261544000;
    localparam logic [22:0] RST_ESC_LIMIT = 23'd65536;

    // micro-op kinds
    localparam logic [2:0] OP_MUL  = 3'd0; // signed product at fraction bits
    localparam logic [2:0] OP_MULW = 3'd1; // product by a q0.32 weight
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_CHK  = 3'd4; // escape test and loop control

    // operand and destination selects
    localparam logic [4:0] SEL_ZERO = 5'd0;
    localparam logic [4:0] SEL_ONE  = 5'd1;
    localparam logic [4:0] SEL_ZR   = 5'd2;
    localparam logic [4:0] SEL_ZI   = 5'd3;
    localparam logic [4:0] SEL_DR   = 5'd4;
    localparam logic [4:0] SEL_DI   = 5'd5;
    localparam logic [4:0] SEL_ER   = 5'd6;
    localparam logic [4:0] SEL_EI   = 5'd7;
    localparam logic [4:0] SEL_SR   = 5'd8;
    localparam logic [4:0] SEL_SI   = 5'd9;
    localparam logic [4:0] SEL_T1   = 5'd10;
    localparam logic [4:0] SEL_T2   = 5'd11;
    localparam logic [4:0] SEL_T3   = 5'd12;
    localparam logic [4:0] SEL_CR   = 5'd13;
    localparam logic [4:0] SEL_CI   = 5'd14;
    localparam logic [4:0] SEL_W    = 5'd15;
    localparam logic [4:0] SEL_RT   = 5'd16;
    localparam logic [4:0] SEL_RS   = 5'd17;

    localparam logic [5:0] PC_CHK  = 6'd43;
    localparam logic [5:0] PC_INIT = 6'd44;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] dst;
        logic [4:0] src_a;
        logic [4:0] src_b;
    } t_uop;

    typedef struct packed {
        logic        start;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic        neg;
        logic        frac;
    } t_mul_req;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
        logic [63:0]  value;
        logic         sat;
    } t_mul_rsp;

    function automatic t_uop uop_at(input logic [5:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = '{OP_MULW, SEL_T1, SEL_ER, SEL_W};
            6'd1:  u = '{OP_ADD,  SEL_SR, SEL_SR, SEL_T1};
            6'd2:  u = '{OP_MULW, SEL_T1, SEL_EI, SEL_W};
            6'd3:  u = '{OP_ADD,  SEL_SI, SEL_SI, SEL_T1};
            6'd4:  u = '{OP_MUL,  SEL_T1, SEL_ZR, SEL_ER};
            6'd5:  u = '{OP_MUL,  SEL_T2, SEL_ZI, SEL_EI};
            6'd6:  u = '{OP_SUB,  SEL_T1, SEL_T1, SEL_T2};
            6'd7:  u = '{OP_MUL,  SEL_T2, SEL_DR, SEL_DR};
            6'd8:  u = '{OP_ADD,  SEL_T1, SEL_T1, SEL_T2};
            6'd9:  u = '{OP_MUL,  SEL_T2, SEL_DI, SEL_DI};
            6'd10: u = '{OP_SUB,  SEL_T1, SEL_T1, SEL_T2};
            6'd11: u = '{OP_ADD,  SEL_T3, SEL_T1, SEL_T1};
            6'd12: u = '{OP_MUL,  SEL_T1, SEL_ZR, SEL_EI};
            6'd13: u = '{OP_MUL,  SEL_T2, SEL_ZI, SEL_ER};
            6'd14: u = '{OP_ADD,  SEL_T1, SEL_T1, SEL_T2};
            6'd15: u = '{OP_MUL,  SEL_T2, SEL_DR, SEL_DI};
            6'd16: u = '{OP_ADD,  SEL_T2, SEL_T2, SEL_T2};
            6'd17: u = '{OP_ADD,  SEL_T1, SEL_T1, SEL_T2};
            6'd18: u = '{OP_ADD,  SEL_EI, SEL_T1, SEL_T1};
            6'd19: u = '{OP_ADD,  SEL_ER, SEL_T3, SEL_ZERO};
            6'd20: u = '{OP_MUL,  SEL_T1, SEL_ZR, SEL_DR};
            6'd21: u = '{OP_MUL,  SEL_T2, SEL_ZI, SEL_DI};
            6'd22: u = '{OP_SUB,  SEL_T1, SEL_T1, SEL_T2};
            6'd23: u = '{OP_ADD,  SEL_T1, SEL_T1, SEL_T1};
            6'd24: u = '{OP_ADD,  SEL_T3, SEL_T1, SEL_ONE};
            6'd25: u = '{OP_MUL,  SEL_T1, SEL_ZR, SEL_DI};
            6'd26: u = '{OP_MUL,  SEL_T2, SEL_ZI, SEL_DR};
            6'd27: u = '{OP_ADD,  SEL_T1, SEL_T1, SEL_T2};
            6'd28: u = '{OP_ADD,  SEL_DI, SEL_T1, SEL_T1};
            6'd29: u = '{OP_ADD,  SEL_DR, SEL_T3, SEL_ZERO};
            6'd30: u = '{OP_MUL,  SEL_T1, SEL_ZR, SEL_ZR};
            6'd31: u = '{OP_MUL,  SEL_T2, SEL_ZI, SEL_ZI};
            6'd32: u = '{OP_SUB,  SEL_T1, SEL_T1, SEL_T2};
            6'd33: u = '{OP_ADD,  SEL_T3, SEL_T1, SEL_CR};
            6'd34: u = '{OP_MUL,  SEL_T1, SEL_ZR, SEL_ZI};
            6'd35: u = '{OP_ADD,  SEL_T1, SEL_T1, SEL_T1};
            6'd36: u = '{OP_ADD,  SEL_ZI, SEL_T1, SEL_CI};
            6'd37: u = '{OP_ADD,  SEL_ZR, SEL_T3, SEL_ZERO};
            6'd38: u = '{OP_MULW, SEL_W,  SEL_W,  SEL_RT};
            6'd39: u = '{OP_MULW, SEL_RT, SEL_RT, SEL_RS};
            6'd40: u = '{OP_MUL,  SEL_T1, SEL_ZR, SEL_ZR};
            6'd41: u = '{OP_MUL,  SEL_T2, SEL_ZI, SEL_ZI};
            6'd42: u = '{OP_ADD,  SEL_T1, SEL_T1, SEL_T2};
            6'd43: u = '{OP_CHK,  SEL_T1, SEL_T1, SEL_T1};
            6'd44: u = '{OP_MULW, SEL_RT, SEL_W,  SEL_RS};
            default: u = '{OP_ADD, SEL_T1, SEL_T1, SEL_ZERO};
        endcase
        return u;
    endfunction

endpackage

// File: design/mandelbrot_second_derivative_sum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_second_derivative_sum_top
// Each orbit step runs 20 products on the shared multiplier, plus 23 adds
// and an escape check; a setup step comes before the steps and the square
// root that gives the modulus of the weighted sum comes after them.
// A new item is taken once busy falls; the result strobe lasts one cycle.
// Synchronous active-low reset loads the register defaults and idles the block.
// ----------------------------------------------------------------------------
module mandelbrot_second_derivative_sum_top #(
    parameter int FRAC_BITS       = 40,
    parameter int COORD_FRAC_BITS = 28,
    parameter int ITER_MAX_LIMIT  = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  msds_pkg::t_point   i_point,
    output logic               o_done,
    output msds_pkg::t_result  o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata
);

    localparam int CW  = $clog2(ITER_MAX_LIMIT + 1);
    localparam int SH  = FRAC_BITS - COORD_FRAC_BITS - 2;
    localparam int SHL = (SH >= 0) ? SH : 0;
    localparam int SHR = (SH < 0) ? -SH : 0;
    localparam int RS  = FRAC_BITS - 24;
    localparam int RS1 = (RS > 0) ? RS - 1 : 0;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MWAIT = 3'd2;
    localparam logic [2:0] S_SQA   = 3'd3;
    localparam logic [2:0] S_SQB   = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;

    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic [12:0] r_max_iter;
    logic [31:0] r_reg_first;
    logic [31:0] r_reg_step;
    logic [22:0] r_esc_limit;

    logic [63:0] r_zr, r_zi, r_dr, r_di, r_er, r_ei, r_sr, r_si;
    logic [63:0] r_t1, r_t2, r_t3, r_cr, r_ci;
    logic [31:0] r_w, r_rt;
    logic [127:0] r_sq;

    logic [2:0]   r_state;
    logic [5:0]   r_pc;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_last;
    logic         r_esc;
    logic         r_sat;
    logic         r_done;
    msds_pkg::t_result  r_result;
    msds_pkg::t_mul_req r_mreq;
    msds_pkg::t_mul_rsp mul_rsp;

    msds_pkg::t_uop uop;
    logic [63:0] op_a, op_b;
    logic [63:0] sum, diff, alu_val;
    logic        add_ovf, sub_ovf, alu_sat;
    logic        is_mul, is_alu;
    logic        wb_en;
    logic [63:0] wb_val;
    logic [63:0] esc_ip;
    logic        over;
    logic        loop_end;
    logic [CW-1:0] last_c;
    logic        run_steps;
    logic [5:0]  pc_next;
    logic        leave_init;
    logic signed [63:0] px, py;
    logic [63:0] c_re, c_im;
    logic        sqrt_go;
    logic [127:0] rad;
    logic        sqrt_done;
    logic [63:0] root;
    logic [64:0] m65;
    logic        fin_sat;
    logic        accept;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] rd(input logic [4:0] sel);
        logic [63:0] v;
        unique case (sel)
            msds_pkg::SEL_ZERO: v = '0;
            msds_pkg::SEL_ONE:  v = ONE;
            msds_pkg::SEL_ZR:   v = r_zr;
            msds_pkg::SEL_ZI:   v = r_zi;
            msds_pkg::SEL_DR:   v = r_dr;
            msds_pkg::SEL_DI:   v = r_di;
            msds_pkg::SEL_ER:   v = r_er;
            msds_pkg::SEL_EI:   v = r_ei;
            msds_pkg::SEL_SR:   v = r_sr;
            msds_pkg::SEL_SI:   v = r_si;
            msds_pkg::SEL_T1:   v = r_t1;
            msds_pkg::SEL_T2:   v = r_t2;
            msds_pkg::SEL_T3:   v = r_t3;
            msds_pkg::SEL_CR:   v = r_cr;
            msds_pkg::SEL_CI:   v = r_ci;
            msds_pkg::SEL_W:    v = {32'b0, r_w};
            msds_pkg::SEL_RT:   v = {32'b0, r_rt};
            msds_pkg::SEL_RS:   v = {32'b0, r_reg_step};
            default:            v = '0;
        endcase
        return v;
    endfunction

    assign accept = start && !busy;
    assign busy   = r_state != S_IDLE;

    // micro-op decode and saturating alu
    always_comb begin
        uop     = msds_pkg::uop_at(r_pc);
        op_a    = rd(uop.src_a);
        op_b    = rd(uop.src_b);
        sum     = op_a + op_b;
        diff    = op_a - op_b;
        add_ovf = (op_a[63] == op_b[63]) && (sum[63] != op_a[63]);
        sub_ovf = (op_a[63] != op_b[63]) && (diff[63] != op_a[63]);
        is_mul  = (uop.op == msds_pkg::OP_MUL) || (uop.op == msds_pkg::OP_MULW);
        is_alu  = (uop.op == msds_pkg::OP_ADD) || (uop.op == msds_pkg::OP_SUB);
        if (uop.op == msds_pkg::OP_SUB) begin
            alu_sat = sub_ovf;
            alu_val = sub_ovf ? (op_a[63] ? 64'h8000_0000_0000_0000
                                          : 64'h7FFF_FFFF_FFFF_FFFF) : diff;
        end else begin
            alu_sat = add_ovf;
            alu_val = add_ovf ? (op_a[63] ? 64'h8000_0000_0000_0000
                                          : 64'h7FFF_FFFF_FFFF_FFFF) : sum;
        end
        wb_en  = ((r_state == S_EXEC) && is_alu) || ((r_state == S_MWAIT) && mul_rsp.done);
        wb_val = (r_state == S_MWAIT) ? mul_rsp.value : alu_val;
    end

    // escape test and loop control
    always_comb begin
        esc_ip     = op_b >> FRAC_BITS;
        over       = (esc_ip > {41'b0, r_esc_limit}) ||
                     ((esc_ip == {41'b0, r_esc_limit}) && (op_b[FRAC_BITS-1:0] != '0));
        loop_end   = ({1'b0, r_cnt} + 1'b1) >= {1'b0, r_last};
        run_steps  = {{(CW-1){1'b0}}, 1'b1} < r_last;
        leave_init = (r_pc == msds_pkg::PC_INIT) && !run_steps;
        pc_next    = (r_pc == msds_pkg::PC_INIT) ? 6'd0 : (r_pc + 6'd1);
        last_c     = (32'(r_max_iter) > 32'(ITER_MAX_LIMIT)) ? CW'(ITER_MAX_LIMIT)
                                                              : CW'(r_max_iter);
    end

    // point to c: re = point_re / 4 - 1, im = point_im / 4, floor on a right shift
    always_comb begin
        px   = 64'(i_point.point_re);
        py   = 64'(i_point.point_im);
        c_re = ((SH >= 0) ? (px <<< SHL) : (px >>> SHR)) - ONE;
        c_im = (SH >= 0) ? (py <<< SHL) : (py >>> SHR);
    end

    assign sqrt_go = (r_state == S_SQB) && mul_rsp.done;
    assign rad     = r_sq + mul_rsp.prod;

    always_comb begin
        m65     = {1'b0, root >> RS} + ((RS > 0) ? 65'(root[RS1]) : 65'd0);
        fin_sat = m65[64:48] != '0;
    end

    msds_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_rsp   (mul_rsp)
    );

    msds_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_go),
        .i_radicand (rad),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= msds_pkg::RST_MAX_ITER;
            r_reg_first <= msds_pkg::RST_REG_FIRST;
            r_reg_step  <= msds_pkg::RST_REG_STEP;
            r_esc_limit <= msds_pkg::RST_ESC_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                msds_pkg::REG_MAX_ITER:  r_max_iter  <= i_cfg_wdata[12:0];
                msds_pkg::REG_REG_FIRST: r_reg_first <= i_cfg_wdata;
                msds_pkg::REG_REG_STEP:  r_reg_step  <= i_cfg_wdata;
                msds_pkg::REG_ESC_LIMIT: r_esc_limit <= i_cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cr <= c_re;
            r_ci <= c_im;
            r_zr <= c_re;
            r_zi <= c_im;
            r_dr <= ONE;
            r_di <= '0;
            r_er <= '0;
            r_ei <= '0;
            r_sr <= '0;
            r_si <= '0;
            r_w  <= r_reg_first;
        end else if (wb_en) begin
            unique case (uop.dst)
                msds_pkg::SEL_ZR: r_zr <= wb_val;
                msds_pkg::SEL_ZI: r_zi <= wb_val;
                msds_pkg::SEL_DR: r_dr <= wb_val;
                msds_pkg::SEL_DI: r_di <= wb_val;
                msds_pkg::SEL_ER: r_er <= wb_val;
                msds_pkg::SEL_EI: r_ei <= wb_val;
                msds_pkg::SEL_SR: r_sr <= wb_val;
                msds_pkg::SEL_SI: r_si <= wb_val;
                msds_pkg::SEL_T1: r_t1 <= wb_val;
                msds_pkg::SEL_T2: r_t2 <= wb_val;
                msds_pkg::SEL_T3: r_t3 <= wb_val;
                msds_pkg::SEL_W:  r_w  <= wb_val[31:0];
                msds_pkg::SEL_RT: r_rt <= wb_val[31:0];
                default: ;
            endcase
        end
        if (r_state == S_SQA && mul_rsp.done) begin
            r_sq <= mul_rsp.prod;
        end
        if (r_state == S_ROOT && sqrt_done) begin
            r_result.magnitude <= fin_sat ? 48'hFFFF_FFFF_FFFF : m65[47:0];
            r_result.escaped   <= r_esc;
            r_result.saturated <= r_sat | fin_sat;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_last  <= '0;
            r_esc   <= 1'b0;
            r_sat   <= 1'b0;
            r_done  <= 1'b0;
            r_mreq  <= '0;
        end else begin
            r_done       <= 1'b0;
            r_mreq.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                        r_pc    <= msds_pkg::PC_INIT;
                        r_cnt   <= {{(CW-1){1'b0}}, 1'b1};
                        r_last  <= last_c;
                        r_esc   <= 1'b0;
                        r_sat   <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (is_mul) begin
                        r_mreq  <= '{1'b1, mag(op_a), mag(op_b), op_a[63] ^ op_b[63],
                                     uop.op == msds_pkg::OP_MUL};
                        r_state <= S_MWAIT;
                    end else if (is_alu) begin
                        r_sat <= r_sat | alu_sat;
                        r_pc  <= pc_next;
                    end else if (over || loop_end) begin
                        r_esc   <= over;
                        r_mreq  <= '{1'b1, mag(r_sr), mag(r_sr), 1'b0, 1'b0};
                        r_state <= S_SQA;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_pc  <= '0;
                    end
                end
                S_MWAIT: begin
                    if (mul_rsp.done) begin
                        r_sat <= r_sat | mul_rsp.sat;
                        r_pc  <= pc_next;
                        if (leave_init) begin
                            r_mreq  <= '{1'b1, mag(r_sr), mag(r_sr), 1'b0, 1'b0};
                            r_state <= S_SQA;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SQA: begin
                    if (mul_rsp.done) begin
                        r_mreq  <= '{1'b1, mag(r_si), mag(r_si), 1'b0, 1'b0};
                        r_state <= S_SQB;
                    end
                end
                S_SQB: begin
                    if (mul_rsp.done) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (sqrt_done) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("item accepted but block not busy");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == S_MWAIT || r_state == S_SQA || r_state == S_SQB))
        else $error("multiplier finished with no waiting state");

endmodule

// File: design/msds_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msds_mul
// Shared 64 x 64 magnitude multiplier built from one 32 x 32 multiplier,
// with rounding, shift and signed saturation of the result.
// ----------------------------------------------------------------------------
module msds_mul #(
    parameter int FRAC_BITS = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msds_pkg::t_mul_req  i_req,
    output msds_pkg::t_mul_rsp  o_rsp
);

    logic         r_run;
    logic [2:0]   r_k;
    logic         r_done;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_neg;
    logic         r_frac;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic [63:0]  r_value;
    logic         r_sat;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp_c;
    logic [1:0]   j;
    logic [127:0] acc_term;
    logic [127:0] half;
    logic [127:0] rnd;
    logic         ovf;
    logic [63:0]  umag;
    logic [63:0]  lim;
    logic         psat;
    logic [63:0]  m;

    always_comb begin
        pa = r_k[1] ? r_a[63:32] : r_a[31:0];
        pb = r_k[0] ? r_b[63:32] : r_b[31:0];
    end

    assign pp_c = pa * pb;
    assign j    = 2'(r_k - 3'd1);

    always_comb begin
        case (j)
            2'd0:    acc_term = {64'b0, r_pp};
            2'd3:    acc_term = {r_pp, 64'b0};
            default: acc_term = {32'b0, r_pp, 32'b0};
        endcase
    end

    always_comb begin
        half = r_frac ? (128'd1 << (FRAC_BITS - 1)) : (128'd1 << 31);
        rnd  = r_acc + half;
        ovf  = r_frac ? (rnd[127:FRAC_BITS+64] != '0) : (rnd[127:96] != '0);
        umag = ovf ? '1 : (r_frac ? rnd[FRAC_BITS+63:FRAC_BITS] : rnd[95:32]);
        lim  = r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        psat = umag > lim;
        m    = psat ? lim : umag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_k    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_k   <= '0;
            end else if (r_run) begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd5) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.mag_a;
            r_b    <= i_req.mag_b;
            r_neg  <= i_req.neg;
            r_frac <= i_req.frac;
            r_acc  <= '0;
        end else if (r_run) begin
            if (r_k <= 3'd3) begin
                r_pp <= pp_c;
            end
            if (r_k >= 3'd1 && r_k <= 3'd4) begin
                r_acc <= r_acc + acc_term;
            end
            if (r_k == 3'd5) begin
                r_value <= r_neg ? (64'd0 - m) : m;
                r_sat   <= ovf | psat;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.prod  = r_acc;
    assign o_rsp.value = r_value;
    assign o_rsp.sat   = r_sat;

endmodule

// File: design/msds_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msds_sqrt
// Restoring floor square root of a 128-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module msds_sqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_radicand,
    output logic         o_done,
    output logic [63:0]  o_root
);

    logic         r_run;
    logic [5:0]   r_i;
    logic         r_done;
    logic [127:0] r_rad;
    logic [65:0]  r_rem;
    logic [63:0]  r_root;

    logic [65:0]  rem_sh;
    logic [65:0]  trial;
    logic         take;

    assign rem_sh = {r_rem[63:0], r_rad[127:126]};
    assign trial  = {r_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_i    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_i   <= '0;
            end else if (r_run) begin
                r_i <= r_i + 6'd1;
                if (r_i == 6'd63) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad  <= {r_rad[125:0], 2'b00};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[62:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the second-derivative sum block. Points and
// register writes are queued up front and fed to the block in random bursts.
// Every accepted point is run through a bit-accurate fixed-point model of the
// orbit, derivative and weighted-sum recurrences. Each result strobe is then
// checked field by field against the oldest expected value.
// ----------------------------------------------------------------------------
module tb;

    localparam int  FRAC      = 40;
    localparam int  ITER_CAP  = 4096;
    localparam int  TIMEOUT   = 4000000;
    localparam int  END_DRAIN = 300;

    typedef struct {
        logic       is_cfg;
        logic [1:0] addr;
        logic [31:0] data;
        msds_pkg::t_point pt;
    } t_job;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start_r = 1'b0;
    logic        busy;
    msds_pkg::t_point  pt_r = '0;
    logic        o_done;
    msds_pkg::t_result o_result;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;

    t_job        job_q[$];
    msds_pkg::t_result sum_q[$];
    msds_pkg::t_point  cur_pt;
    int          errs       = 0;
    int          cyc        = 0;
    int          gap        = 0;
    int          burst_left = 1;

    logic [12:0] sh_max_iter  = msds_pkg::RST_MAX_ITER;
    logic [31:0] sh_reg_first = msds_pkg::RST_REG_FIRST;
    logic [31:0] sh_reg_step  = msds_pkg::RST_REG_STEP;
    logic [22:0] sh_esc_limit = msds_pkg::RST_ESC_LIMIT;
    logic        clip;

    mandelbrot_second_derivative_sum_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start_r),
        .busy       (busy),
        .i_point    (pt_r),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // fixed-point helpers
    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] umul_rnd(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        q = p >> sh;
        if (q[127:64] != 0) begin
            clip = 1'b1;
            return '1;
        end
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] pack_s(logic neg, logic [63:0] m);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        if (m > lim) begin
            clip = 1'b1;
            m = lim;
        end
        return neg ? $signed(-m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] smul(logic signed [63:0] a, logic signed [63:0] b);
        return pack_s(a[63] ^ b[63], umul_rnd(mag(a), mag(b), FRAC));
    endfunction

    function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            clip = 1'b1;
            return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sub_sat(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            clip = 1'b1;
            return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        end
        return r;
    endfunction

    function automatic logic [31:0] wmul(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b} + 64'h8000_0000;
        return p[63:32];
    endfunction

    function automatic logic signed [63:0] weigh(logic signed [63:0] v, logic [31:0] w);
        return pack_s(v[63], umul_rnd(mag(v), {32'd0, w}, 32));
    endfunction

    function automatic logic beyond_escape(logic signed [63:0] m);
        logic [63:0] ip;
        ip = $unsigned(m) >> FRAC;
        return ip > sh_esc_limit || (ip == sh_esc_limit && m[FRAC-1:0] != 0);
    endfunction

    function automatic logic [47:0] sum_modulus(logic signed [63:0] re, logic signed [63:0] im);
        logic [127:0] s;
        logic [63:0]  r;
        logic [63:0]  c;
        logic [63:0]  m;
        s = {64'd0, mag(re)} * {64'd0, mag(re)} + {64'd0, mag(im)} * {64'd0, mag(im)};
        r = 0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            c = r | (64'd1 << bit_i);
            if ({64'd0, c} * {64'd0, c} <= s) r = c;
        end
        m = (r >> (FRAC - 24)) + ((r >> (FRAC - 25)) & 64'd1);
        if (m > 64'hffff_ffff_ffff) begin
            clip = 1'b1;
            m = 64'hffff_ffff_ffff;
        end
        return m[47:0];
    endfunction

    function automatic msds_pkg::t_result predict_sum(msds_pkg::t_point p);
        logic signed [63:0] c_re, c_im, zr, zi, dr, di, er, ei, sr, si, t, nre, nim;
        logic [31:0] w, rt;
        int          last;
        logic        esc;
        msds_pkg::t_result res;
        clip = 1'b0;
        esc  = 1'b0;
        last = (sh_max_iter > ITER_CAP) ? ITER_CAP : sh_max_iter;
        c_re = ($signed({{32{p.point_re[31]}}, p.point_re}) <<< 10) - (64'sd1 <<< FRAC);
        c_im = $signed({{32{p.point_im[31]}}, p.point_im}) <<< 10;
        zr = c_re;
        zi = c_im;
        dr = 64'sd1 <<< FRAC;
        di = 0;
        er = 0;
        ei = 0;
        sr = 0;
        si = 0;
        w  = sh_reg_first;
        rt = wmul(sh_reg_first, sh_reg_step);
        for (int n = 1; n < last; n++) begin
            sr = add_sat(sr, weigh(er, w));
            si = add_sat(si, weigh(ei, w));
            t = sub_sat(smul(zr, er), smul(zi, ei));
            t = add_sat(t, smul(dr, dr));
            t = sub_sat(t, smul(di, di));
            nre = add_sat(t, t);
            t = add_sat(smul(zr, ei), smul(zi, er));
            nim = smul(dr, di);
            t = add_sat(t, add_sat(nim, nim));
            ei = add_sat(t, t);
            er = nre;
            t = sub_sat(smul(zr, dr), smul(zi, di));
            nre = add_sat(add_sat(t, t), 64'sd1 <<< FRAC);
            t = add_sat(smul(zr, di), smul(zi, dr));
            di = add_sat(t, t);
            dr = nre;
            nre = add_sat(sub_sat(smul(zr, zr), smul(zi, zi)), c_re);
            t = smul(zr, zi);
            nim = add_sat(add_sat(t, t), c_im);
            zr = nre;
            zi = nim;
            w  = wmul(w, rt);
            rt = wmul(rt, sh_reg_step);
            if (beyond_escape(add_sat(smul(nre, nre), smul(nim, nim)))) begin
                esc = 1'b1;
                break;
            end
        end
        res.magnitude = sum_modulus(sr, si);
        res.escaped   = esc;
        res.saturated = clip;
        return res;
    endfunction

    task automatic push_cfg(logic [1:0] addr, logic [31:0] data);
        t_job j;
        j.is_cfg = 1'b1;
        j.addr   = addr;
        j.data   = data;
        j.pt     = '0;
        job_q.push_back(j);
    endtask

    task automatic push_pt(logic [31:0] re, logic [31:0] im);
        t_job j;
        j.is_cfg = 1'b0;
        j.addr   = '0;
        j.data   = '0;
        j.pt.point_re = re;
        j.pt.point_im = im;
        job_q.push_back(j);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1, 2: return $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
            default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        logic nx_start;
        logic nx_we;
        logic took;
        t_job j;
        if (!i_rst_n) begin
            start_r <= 1'b0;
            cfg_we  <= 1'b0;
        end else begin
            nx_start = start_r;
            nx_we    = 1'b0;
            took     = 1'b0;
            if (start_r && !busy) begin
                sum_q.push_back(predict_sum(cur_pt));
                nx_start = 1'b0;
                took     = 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    burst_left = $urandom_range(1, 8);
                end
            end
            if (!nx_start) begin
                if (gap > 0) begin
                    gap--;
                end else if (job_q.size() > 0) begin
                    if (job_q[0].is_cfg) begin
                        if (!took && sum_q.size() == 0 && !busy) begin
                            j = job_q.pop_front();
                            case (j.addr)
                                msds_pkg::REG_MAX_ITER:  sh_max_iter  = j.data[12:0];
                                msds_pkg::REG_REG_FIRST: sh_reg_first = j.data;
                                msds_pkg::REG_REG_STEP:  sh_reg_step  = j.data;
                                msds_pkg::REG_ESC_LIMIT: sh_esc_limit = j.data[22:0];
                                default: ;
                            endcase
                            nx_we = 1'b1;
                            cfg_addr <= j.addr;
                            cfg_data <= j.data;
                        end
                    end else begin
                        j = job_q.pop_front();
                        cur_pt   = j.pt;
                        pt_r     <= j.pt;
                        nx_start = 1'b1;
                    end
                end
            end
            start_r <= nx_start;
            cfg_we  <= nx_we;
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        msds_pkg::t_result e;
        if (i_rst_n && o_done) begin
            if (sum_q.size() == 0) begin
                $error("unexpected result: magnitude %0h", o_result.magnitude);
                errs++;
            end else begin
                e = sum_q.pop_front();
                if (o_result.magnitude !== e.magnitude) begin
                    $error("magnitude: expected %0h, got %0h", e.magnitude, o_result.magnitude);
                    errs++;
                end
                if (o_result.escaped !== e.escaped) begin
                    $error("escaped: expected %0b, got %0b", e.escaped, o_result.escaped);
                    errs++;
                end
                if (o_result.saturated !== e.saturated) begin
                    $error("saturated: expected %0b, got %0b", e.saturated, o_result.saturated);
                    errs++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > TIMEOUT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int esc_pick;
        // directed: default registers
        push_pt(32'h0000_0000, 32'h0000_0000);
        push_pt(32'h7fff_ffff, 32'h8000_0000);
        // short count
        push_cfg(msds_pkg::REG_MAX_ITER, 32'd1);
        push_pt(32'h8000_0000, 32'h7fff_ffff);
        push_cfg(msds_pkg::REG_MAX_ITER, 32'd0);
        push_pt(32'h1234_5678, 32'hedcb_a988);
        // zero weights
        push_cfg(msds_pkg::REG_MAX_ITER, 32'd2);
        push_cfg(msds_pkg::REG_REG_FIRST, 32'd0);
        push_cfg(msds_pkg::REG_REG_STEP, 32'd0);
        push_pt(32'h1000_0000, 32'h0000_0000);
        push_pt(32'hf000_0000, 32'h0800_0000);
        // long count with full weights, tight escape bound
        push_cfg(msds_pkg::REG_MAX_ITER, 32'h1fff);
        push_cfg(msds_pkg::REG_ESC_LIMIT, 32'd4);
        push_cfg(msds_pkg::REG_REG_FIRST, 32'hffff_ffff);
        push_cfg(msds_pkg::REG_REG_STEP, 32'hffff_ffff);
        push_pt(32'h7fff_ffff, 32'h7fff_ffff);
        push_pt(32'h8000_0000, 32'h8000_0000);
        push_pt(32'h8000_0000, 32'h0000_0000);
        push_pt(32'h7fff_ffff, 32'h0000_0000);
        push_cfg(msds_pkg::REG_MAX_ITER, 32'd4096);
        push_pt(32'h8000_0000, 32'h7fff_ffff);
        // widest escape bound, clipped values
        push_cfg(msds_pkg::REG_ESC_LIMIT, 32'h7f_ffff);
        push_cfg(msds_pkg::REG_MAX_ITER, 32'd40);
        push_cfg(msds_pkg::REG_REG_FIRST, msds_pkg::RST_REG_FIRST);
        push_pt(32'h7fff_ffff, 32'h7fff_ffff);
        push_pt(32'h8000_0000, 32'h8000_0000);
        push_pt(32'h4000_0000, 32'h0000_0000);
        push_pt(32'hc000_0000, 32'h0000_0000);
        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            push_cfg(msds_pkg::REG_MAX_ITER,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                 : $urandom_range(2, 16));
            push_cfg(msds_pkg::REG_REG_FIRST,
                     ($urandom_range(0, 3) == 0) ? msds_pkg::RST_REG_FIRST : $urandom());
            push_cfg(msds_pkg::REG_REG_STEP,
                     ($urandom_range(0, 3) == 0) ? msds_pkg::RST_REG_STEP : $urandom());
            esc_pick = $urandom_range(0, 3);
            case (esc_pick)
                0: push_cfg(msds_pkg::REG_ESC_LIMIT, 32'd4);
                1: push_cfg(msds_pkg::REG_ESC_LIMIT, $urandom_range(4, 64));
                2: push_cfg(msds_pkg::REG_ESC_LIMIT, $urandom_range(4, 32'h7f_ffff));
                default: push_cfg(msds_pkg::REG_ESC_LIMIT, 32'h7f_ffff);
            endcase
            for (int k = 0; k < 29; k++) push_pt(rand_coord(), rand_coord());
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (job_q.size() != 0 || start_r || sum_q.size() != 0);
        repeat (END_DRAIN) @(posedge i_clk);
        if (errs == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/msds_pkg.sv
design/msds_mul.sv
design/msds_sqrt.sv
design/mandelbrot_second_derivative_sum_top.sv
sim/tb.sv
